>>> hdl/tam_pkg.sv
// Shared constants and codes for the tracker accuracy metrics block.
package tam_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  localparam int THRESH_BITS = 18;
  localparam int DIST_BITS   = 19;
  localparam int MOTA_BITS   = 16;
  localparam int MOTA_FRAC   = 14;
  localparam int SQ_SHIFT    = 8;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 18'd8000;
  localparam logic [DIST_BITS-1:0]   DIST_MAX     = 19'h7FFFF;
  localparam logic [16:0]            ONE_Q14      = 17'd16384;
  localparam logic [16:0]            Q_CLAMP      = 17'd32768;

  localparam logic [1:0] KIND_MISS = 2'd0;
  localparam logic [1:0] KIND_A    = 2'd1;
  localparam logic [1:0] KIND_B    = 2'd2;

endpackage

>>> hdl/tam_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module tam_sqrt #(
  parameter int RAD_W = 36
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] test;
  logic [ROOT_W+2:0] diff;
  logic              take;

  assign trial = {rem, rad[RAD_W-1 -: 2]};
  assign test  = (ROOT_W + 3)'({root, 2'b01});
  assign take  = trial >= test;
  assign diff  = trial - test;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? diff[ROOT_W:0] : trial[ROOT_W:0];
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule

>>> hdl/tam_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tam_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  assign trial = {rem, quotient[NUM_W-1]};
  assign take  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[NUM_W-2:0], take};
      rem      <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

>>> hdl/tracker_accuracy_metrics_top.sv
// Top level of the tracker accuracy metrics block: box distances, frame class, MOTP and MOTA.
//
//   channel   handshake               carries
//   cfg       cfg_valid / cfg_ready   distance_threshold
//   in        in_valid / in_ready     reference box and hypothesis boxes A and B
//   out       out_valid / out_ready   frame class, flags, frame distance, MOTP, MOTA
//
// The serial square root runs twice (A, B), then the serial divider runs twice (MOTP,
// MOTA). in_ready is high only while idle; a finished result waits in the output
// register while the next request is taken, and a held result stalls the block before
// its load. Reset is synchronous and clears all running sums, the frame count and the
// previous class, and loads the threshold with 8000.
module tracker_accuracy_metrics_top #(
  parameter int COORD_BITS = tam_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = tam_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tam_pkg::THRESH_BITS-1:0]     distance_threshold,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [COORD_BITS-1:0]               ref_x,
  input  logic [COORD_BITS-1:0]               ref_y,
  input  logic [COORD_BITS-1:0]               ref_w,
  input  logic [COORD_BITS-1:0]               ref_h,
  input  logic [COORD_BITS-1:0]               hyp_a_x,
  input  logic [COORD_BITS-1:0]               hyp_a_y,
  input  logic [COORD_BITS-1:0]               hyp_a_w,
  input  logic [COORD_BITS-1:0]               hyp_a_h,
  input  logic [COORD_BITS-1:0]               hyp_b_x,
  input  logic [COORD_BITS-1:0]               hyp_b_y,
  input  logic [COORD_BITS-1:0]               hyp_b_w,
  input  logic [COORD_BITS-1:0]               hyp_b_h,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          match_kind,
  output logic                                miss_flag,
  output logic                                false_positive_flag,
  output logic                                mismatch_flag,
  output logic [tam_pkg::DIST_BITS-1:0]       frame_distance,
  output logic [tam_pkg::DIST_BITS-1:0]       motp_value,
  output logic signed [tam_pkg::MOTA_BITS-1:0] mota_value
);

  import tam_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int D2_W   = 2 * DIFF_W + 1;
  localparam int MUL_W  = (DIFF_W > THRESH_BITS) ? DIFF_W : THRESH_BITS;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SH_W   = D2_W + SQ_SHIFT;
  localparam int CMP_W  = (SH_W > PROD_W) ? SH_W : PROD_W;
  localparam int RAD_W  = SH_W + (SH_W % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int RX_W   = (ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS;
  localparam int DSUM_W = COUNT_BITS + DIST_BITS;
  localparam int ESUM_W = COUNT_BITS + 2;
  localparam int NUM_W  = DSUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIF  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_CLS  = 4'd3;
  localparam logic [3:0] S_SQA  = 4'd4;
  localparam logic [3:0] S_SQB  = 4'd5;
  localparam logic [3:0] S_FD   = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_DIVP = 4'd8;
  localparam logic [3:0] S_WDP  = 4'd9;
  localparam logic [3:0] S_WDE  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]             state;
  logic [3:0]             state_next;
  logic [2:0]             mul_idx;
  logic [THRESH_BITS-1:0] thresh;
  logic [COUNT_BITS-1:0]  frame_total;
  logic [1:0]             previous_kind;
  logic [DSUM_W-1:0]      distance_sum;
  logic [ESUM_W-1:0]      error_sum;

  logic [DIFF_W-1:0] rcx, rcy, acx, acy, bcx, bcy;
  logic [DIFF_W-1:0] dxa, dya, dxb, dyb;
  logic [MUL_W-1:0]  mul_op;
  logic [PROD_W-1:0] mul_res;
  logic [PROD_W-1:0] prod;
  logic [D2_W-1:0]   d2a, d2b;
  logic [PROD_W-1:0] tsq;

  logic [CMP_W-1:0] sha, shb, tsq_x;
  logic             a_in, b_in, a_close;
  logic [1:0]       kind_c;
  logic             fp_c, mm_c, miss_c;
  logic [1:0]       err_inc;
  logic [ESUM_W:0]  esum_add;

  logic [1:0]           kind;
  logic                 miss, fp, mm;
  logic [DIST_BITS-1:0] da, db, fd;
  logic [DIST_BITS:0]   fd_sum;
  logic [DIST_BITS-1:0] fd_pick;
  logic [DSUM_W:0]      dsum_add;
  logic [DIST_BITS-1:0] motp_w;
  logic [MOTA_BITS-1:0] mota_w;

  logic              sqrt_start, sqrt_done;
  logic [RAD_W-1:0]  sqrt_rad;
  logic [ROOT_W-1:0] sqrt_root;
  logic [RX_W-1:0]   root_x;
  logic [DIST_BITS-1:0] root_sat;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_quot;
  logic [16:0]      q_c;
  logic [16:0]      mota_full;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    case (mul_idx)
      3'd0:    mul_op = MUL_W'(dxa);
      3'd1:    mul_op = MUL_W'(dya);
      3'd2:    mul_op = MUL_W'(dxb);
      3'd3:    mul_op = MUL_W'(dyb);
      default: mul_op = MUL_W'(thresh);
    endcase
  end
  assign mul_res = mul_op * mul_op;

  assign sha     = CMP_W'({d2a, {SQ_SHIFT{1'b0}}});
  assign shb     = CMP_W'({d2b, {SQ_SHIFT{1'b0}}});
  assign tsq_x   = CMP_W'(tsq);
  assign a_in    = sha < tsq_x;
  assign b_in    = shb < tsq_x;
  assign a_close = d2a <= d2b;

  always_comb begin
    kind_c = KIND_MISS;
    fp_c   = 1'b0;
    miss_c = 1'b0;
    if (a_in) begin
      kind_c = a_close ? KIND_A : KIND_B;
      fp_c   = a_close ? b_in : 1'b1;
    end else if (b_in) begin
      kind_c = KIND_B;
    end else begin
      miss_c = 1'b1;
    end
    mm_c = (kind_c != KIND_MISS) && (frame_total >= COUNT_BITS'(2)) &&
           (kind_c != previous_kind);
  end

  assign err_inc  = 2'({1'b0, miss_c}) + 2'({1'b0, fp_c}) + 2'({1'b0, mm_c});
  assign esum_add = {1'b0, error_sum} + (ESUM_W + 1)'(err_inc);

  assign sqrt_start = (state == S_CLS) || ((state == S_SQA) && sqrt_done);
  assign sqrt_rad   = RAD_W'({((state == S_CLS) ? d2a : d2b), {SQ_SHIFT{1'b0}}});
  assign root_x     = RX_W'(sqrt_root);
  assign root_sat   = (root_x > RX_W'(DIST_MAX)) ? DIST_MAX : root_x[DIST_BITS-1:0];

  assign fd_sum = {1'b0, da} + {1'b0, db};
  always_comb begin
    if (miss) begin
      fd_pick = '0;
    end else if (fp) begin
      fd_pick = fd_sum[DIST_BITS] ? DIST_MAX : fd_sum[DIST_BITS-1:0];
    end else if (kind == KIND_A) begin
      fd_pick = da;
    end else begin
      fd_pick = db;
    end
  end
  assign dsum_add = {1'b0, distance_sum} + (DSUM_W + 1)'(fd);

  assign div_start = (state == S_DIVP) || ((state == S_WDP) && div_done);
  assign div_num   = (state == S_DIVP) ? distance_sum :
                     NUM_W'({error_sum, {MOTA_FRAC{1'b0}}});
  assign q_c       = (div_quot > NUM_W'(Q_CLAMP)) ? Q_CLAMP : div_quot[16:0];
  assign mota_full = ONE_Q14 - q_c;

  tam_sqrt #(
    .RAD_W(RAD_W)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(sqrt_rad),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  tam_div #(
    .NUM_W(NUM_W),
    .DEN_W(COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_num),
    .divisor (frame_total),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIF;
      S_DIF:  state_next = S_SQ;
      S_SQ:   if (mul_idx == 3'd5) state_next = S_CLS;
      S_CLS:  state_next = S_SQA;
      S_SQA:  if (sqrt_done) state_next = S_SQB;
      S_SQB:  if (sqrt_done) state_next = S_FD;
      S_FD:   state_next = S_SUM;
      S_SUM:  state_next = S_DIVP;
      S_DIVP: state_next = S_WDP;
      S_WDP:  if (div_done) state_next = S_WDE;
      S_WDE:  if (div_done) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mul_idx       <= '0;
      thresh        <= THRESH_RESET;
      frame_total   <= '0;
      previous_kind <= KIND_MISS;
      distance_sum  <= '0;
      error_sum     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        thresh <= distance_threshold;
      end
      if (state == S_DIF) begin
        mul_idx <= '0;
      end else if (state == S_SQ) begin
        mul_idx <= mul_idx + 3'd1;
      end
      if (state == S_CLS) begin
        previous_kind <= kind_c;
        if (frame_total != '1) begin
          frame_total <= frame_total + COUNT_BITS'(1);
        end
        error_sum <= esum_add[ESUM_W] ? '1 : esum_add[ESUM_W-1:0];
      end
      if (state == S_SUM) begin
        distance_sum <= dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rcx <= DIFF_W'(ref_x)   + DIFF_W'(ref_w >> 1);
      rcy <= DIFF_W'(ref_y)   + DIFF_W'(ref_h >> 1);
      acx <= DIFF_W'(hyp_a_x) + DIFF_W'(hyp_a_w >> 1);
      acy <= DIFF_W'(hyp_a_y) + DIFF_W'(hyp_a_h >> 1);
      bcx <= DIFF_W'(hyp_b_x) + DIFF_W'(hyp_b_w >> 1);
      bcy <= DIFF_W'(hyp_b_y) + DIFF_W'(hyp_b_h >> 1);
    end
    if (state == S_DIF) begin
      dxa <= (rcx >= acx) ? rcx - acx : acx - rcx;
      dya <= (rcy >= acy) ? rcy - acy : acy - rcy;
      dxb <= (rcx >= bcx) ? rcx - bcx : bcx - rcx;
      dyb <= (rcy >= bcy) ? rcy - bcy : bcy - rcy;
    end
    if (state == S_SQ) begin
      prod <= mul_res;
      case (mul_idx)
        3'd1:    d2a <= D2_W'(prod[2*DIFF_W-1:0]);
        3'd2:    d2a <= d2a + D2_W'(prod[2*DIFF_W-1:0]);
        3'd3:    d2b <= D2_W'(prod[2*DIFF_W-1:0]);
        3'd4:    d2b <= d2b + D2_W'(prod[2*DIFF_W-1:0]);
        3'd5:    tsq <= prod;
        default: ;
      endcase
    end
    if (state == S_CLS) begin
      kind <= kind_c;
      miss <= miss_c;
      fp   <= fp_c;
      mm   <= mm_c;
    end
    if ((state == S_SQA) && sqrt_done) begin
      da <= root_sat;
    end
    if ((state == S_SQB) && sqrt_done) begin
      db <= root_sat;
    end
    if (state == S_FD) begin
      fd <= fd_pick;
    end
    if ((state == S_WDP) && div_done) begin
      motp_w <= (div_quot > NUM_W'(DIST_MAX)) ? DIST_MAX : div_quot[DIST_BITS-1:0];
    end
    if ((state == S_WDE) && div_done) begin
      mota_w <= mota_full[MOTA_BITS-1:0];
    end
    if (out_load) begin
      match_kind          <= kind;
      miss_flag           <= miss;
      false_positive_flag <= fp;
      mismatch_flag       <= mm;
      frame_distance      <= fd;
      motp_value          <= motp_w;
      mota_value          <= mota_w;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && miss_flag |-> match_kind == KIND_MISS && !false_positive_flag &&
                               !mismatch_flag && frame_distance == '0)
    else $error("miss result carries match data");

  a_mota_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mota_value >= -16'sd16384 && mota_value <= 16'sd16384)
    else $error("mota out of range");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> frame_total >= $past(frame_total))
    else $error("frame count decreased");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQA || state == S_SQB)
    else $error("square root finished outside its wait states");
`endif

endmodule

>>> verif/tracker_accuracy_metrics_top_tb.sv
// Self-checking testbench for tracker_accuracy_metrics_top: random-paced frames against a built-in MOT scorer.
`timescale 1ns / 100ps

module tracker_accuracy_metrics_top_tb;
  import tam_pkg::*;

  localparam int CB   = COORD_BITS_DEF;
  localparam int CNTB = COUNT_BITS_DEF;
  localparam int THB  = THRESH_BITS;
  localparam int DB   = DIST_BITS;
  localparam int MB   = MOTA_BITS;
  localparam int CMAX = (1 << CB) - 1;
  localparam logic [THB-1:0] GATE_MAX = '1;
  localparam longint unsigned FRAME_MAX = (64'd1 << CNTB) - 1;
  localparam longint unsigned DSUM_MAX  = (64'd1 << (CNTB + 19)) - 1;
  localparam longint unsigned ESUM_MAX  = (64'd1 << (CNTB + 2)) - 1;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } box_t;

  typedef struct packed {
    box_t truth;
    box_t hyp_a;
    box_t hyp_b;
  } frame_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          miss;
    logic          fp;
    logic          mm;
    logic [DB-1:0] frame_dist;
    logic [DB-1:0] motp;
    logic [MB-1:0] mota;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THB-1:0] distance_threshold = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] ref_x = '0, ref_y = '0, ref_w = '0, ref_h = '0;
  logic [CB-1:0] hyp_a_x = '0, hyp_a_y = '0, hyp_a_w = '0, hyp_a_h = '0;
  logic [CB-1:0] hyp_b_x = '0, hyp_b_y = '0, hyp_b_w = '0, hyp_b_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] match_kind;
  logic miss_flag;
  logic false_positive_flag;
  logic mismatch_flag;
  logic [DB-1:0] frame_distance;
  logic [DB-1:0] motp_value;
  logic signed [MB-1:0] mota_value;

  tracker_accuracy_metrics_top uut (.*);

  always #5 clk = ~clk;

  logic [THB-1:0]  gate_q4 = THRESH_RESET;
  longint unsigned frames_seen = 0;
  longint unsigned dist_total = 0;
  longint unsigned err_total = 0;
  logic [1:0]      last_kind = KIND_MISS;

  frame_t frames_to_send[$];
  score_t scores_due[$];
  int     fail_count = 0;
  int     scores_seen = 0;
  bit     in_took = 1'b0;

  function automatic void queue_frame(frame_t f);
    frames_to_send.insert(frames_to_send.size(), f);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned centre_gap_sq(box_t t, box_t h);
    longint unsigned tx, ty, hx, hy, dx, dy;
    tx = 64'(t.x) + 64'(t.w >> 1);
    ty = 64'(t.y) + 64'(t.h >> 1);
    hx = 64'(h.x) + 64'(h.w >> 1);
    hy = 64'(h.y) + 64'(h.h >> 1);
    dx = (tx >= hx) ? tx - hx : hx - tx;
    dy = (ty >= hy) ? ty - hy : hy - ty;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned q4_clip(longint unsigned v);
    return (v > 64'(DIST_MAX)) ? 64'(DIST_MAX) : v;
  endfunction

  function automatic score_t score_frame(frame_t f);
    longint unsigned d2a, d2b, tsq, da, db, fd, e, q, motp;
    logic a_in, b_in;
    score_t s;
    d2a = centre_gap_sq(f.truth, f.hyp_a);
    d2b = centre_gap_sq(f.truth, f.hyp_b);
    tsq = 64'(gate_q4) * 64'(gate_q4);
    a_in = (d2a << SQ_SHIFT) < tsq;
    b_in = (d2b << SQ_SHIFT) < tsq;
    da = q4_clip(root_floor(d2a << SQ_SHIFT));
    db = q4_clip(root_floor(d2b << SQ_SHIFT));
    s = '0;
    if (a_in) begin
      if (d2a <= d2b) begin
        s.kind = KIND_A;
        s.fp = b_in;
      end else begin
        s.kind = KIND_B;
        s.fp = 1'b1;
      end
      fd = s.fp ? da + db : da;
    end else if (b_in) begin
      s.kind = KIND_B;
      fd = db;
    end else begin
      s.kind = KIND_MISS;
      s.miss = 1'b1;
      fd = 0;
    end
    fd = q4_clip(fd);
    s.mm = (s.kind != KIND_MISS) && (frames_seen >= 2) && (s.kind != last_kind);
    last_kind = s.kind;
    if (frames_seen < FRAME_MAX) frames_seen++;
    dist_total = (dist_total > DSUM_MAX - fd) ? DSUM_MAX : dist_total + fd;
    e = 64'(s.miss) + 64'(s.fp) + 64'(s.mm);
    err_total = (err_total > ESUM_MAX - e) ? ESUM_MAX : err_total + e;
    motp = q4_clip(dist_total / frames_seen);
    q = (err_total << MOTA_FRAC) / frames_seen;
    if (q > 64'(Q_CLAMP)) q = 64'(Q_CLAMP);
    s.frame_dist = fd[DB-1:0];
    s.motp = motp[DB-1:0];
    s.mota = MB'(longint'(ONE_Q14) - longint'(q));
    return s;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  score_t want;
  frame_t got_frame;

  always @(posedge clk) begin
    in_took = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        scores_seen++;
        if (scores_due.size() == 0) begin
          fail_count++;
          $display("%0t result expected none actual kind %0d distance %0d",
                   $time, match_kind, frame_distance);
        end else begin
          want = scores_due.pop_front();
          check_field("match_kind", want.kind, match_kind);
          check_field("miss_flag", want.miss, miss_flag);
          check_field("false_positive_flag", want.fp, false_positive_flag);
          check_field("mismatch_flag", want.mm, mismatch_flag);
          check_field("frame_distance", want.frame_dist, frame_distance);
          check_field("motp_value", want.motp, motp_value);
          check_field("mota_value", $signed(want.mota), mota_value);
        end
      end
      if (in_took) begin
        got_frame.truth = '{ref_x, ref_y, ref_w, ref_h};
        got_frame.hyp_a = '{hyp_a_x, hyp_a_y, hyp_a_w, hyp_a_h};
        got_frame.hyp_b = '{hyp_b_x, hyp_b_y, hyp_b_w, hyp_b_h};
        scores_due.insert(scores_due.size(), score_frame(got_frame));
      end
    end
  end

  int     tx_gap = 0;
  bit     tx_calm = 1'b0;
  frame_t nf;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 200);
  endfunction

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (tx_gap > 0 || frames_to_send.size() == 0) begin
        in_valid <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end else begin
        nf = frames_to_send.pop_front();
        {ref_x, ref_y, ref_w, ref_h} <= nf.truth;
        {hyp_a_x, hyp_a_y, hyp_a_w, hyp_a_h} <= nf.hyp_a;
        {hyp_b_x, hyp_b_y, hyp_b_w, hyp_b_h} <= nf.hyp_b;
        in_valid <= 1'b1;
        tx_gap = pick_gap(tx_calm);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      end
    end
  end

  int rx_stall = 0;
  int rx_roll;
  bit rx_calm = 1'b0;
  bit long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else if (!long_hold_done && scores_seen >= 120) begin
        // hold off long enough for the block to fill and stall its input
        out_ready <= 1'b0;
        rx_stall = 2000;
        long_hold_done = 1'b1;
      end else if (rx_calm) begin
        out_ready <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_stall = (rx_roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 150);
        end
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    end
  end

  function automatic logic [CB-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > CMAX) return CMAX[CB-1:0];
    return v[CB-1:0];
  endfunction

  function automatic box_t mk_box(int x, int y, int w, int h);
    box_t b;
    b = '{clamp_coord(x), clamp_coord(y), clamp_coord(w), clamp_coord(h)};
    return b;
  endfunction

  function automatic box_t random_box();
    return mk_box($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                  $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic box_t near_box(box_t c, int span);
    return mk_box(int'(c.x) + jitter(span), int'(c.y) + jitter(span),
                  int'(c.w) + jitter(span), int'(c.h) + jitter(span));
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 3))
      0: return 3;
      1: return 40;
      2: return 400;
      default: return 1500;
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int r;
    f.truth = random_box();
    f.hyp_a = ($urandom_range(0, 9) < 7) ? near_box(f.truth, pick_span()) : random_box();
    r = $urandom_range(0, 9);
    if (r == 0) f.hyp_b = f.hyp_a;
    else if (r < 7) f.hyp_b = near_box(f.truth, pick_span());
    else f.hyp_b = random_box();
    return f;
  endfunction

  function automatic frame_t mk_frame(box_t t, box_t a, box_t b);
    frame_t f;
    f.truth = t;
    f.hyp_a = a;
    f.hyp_b = b;
    return f;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (frames_to_send.size() != 0 || in_valid || scores_due.size() != 0);
    @(negedge clk);
  endtask

  task automatic write_gate(logic [THB-1:0] v);
    wait_idle();
    distance_threshold <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    gate_q4 = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  box_t zb, mb, pc, pa, pb;
  logic [THB-1:0] phase_gate;

  initial begin
    zb = mk_box(0, 0, 0, 0);
    mb = mk_box(CMAX, CMAX, CMAX, CMAX);
    pc = mk_box(1000, 1000, 0, 0);
    pa = mk_box('hAAA, 'h555, 'hAAA, 'h555);
    pb = mk_box('h555, 'hAAA, 'h555, 'hAAA);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset threshold: 500 pixels
    queue_frame(mk_frame(zb, zb, zb));
    queue_frame(mk_frame(mb, mb, mb));
    queue_frame(mk_frame(mk_box(100, 100, 20, 20), mk_box(100, 100, 20, 20),
                         mk_box(3000, 3000, 10, 10)));
    queue_frame(mk_frame(mk_box(100, 100, 20, 20), mk_box(3000, 3000, 10, 10),
                         mk_box(100, 100, 20, 20)));
    queue_frame(mk_frame(pc, mk_box(1499, 1000, 0, 0), mk_box(1010, 1000, 0, 0)));
    queue_frame(mk_frame(pc, mk_box(1500, 1000, 0, 0), mk_box(1000, 1500, 0, 0)));
    queue_frame(mk_frame(pc, mk_box(1300, 1400, 0, 0), mk_box(1000, 1000, 1, 1)));
    queue_frame(mk_frame(pc, mk_box(1030, 1040, 0, 0), mk_box(960, 970, 0, 0)));
    queue_frame(mk_frame(mk_box(10, 10, CMAX, CMAX), mk_box(2057, 2057, 1, 1), zb));
    queue_frame(mk_frame(zb, mb, mb));
    queue_frame(mk_frame(mb, zb, mb));
    queue_frame(mk_frame(mk_box(500, 500, 7, 9), mk_box(503, 507, 3, 5),
                         mk_box(520, 490, 0, 0)));
    queue_frame(mk_frame(pa, pb, pa));
    queue_frame(mk_frame(pb, pa, pb));

    // zero threshold: every frame is a miss
    write_gate('0);
    repeat (3) queue_frame(mk_frame(pc, pc, pc));
    queue_frame(mk_frame(zb, zb, zb));
    repeat (6) queue_frame(random_frame());

    // widest threshold: every frame matches
    write_gate(GATE_MAX);
    queue_frame(mk_frame(zb, mb, mb));
    queue_frame(mk_frame(mb, zb, mb));
    queue_frame(mk_frame(zb, mb, zb));
    queue_frame(mk_frame(pa, pb, pb));
    repeat (20) queue_frame(random_frame());

    // smallest nonzero threshold: only exact centres match
    write_gate(1);
    queue_frame(mk_frame(pc, pc, mk_box(1001, 1000, 0, 0)));
    queue_frame(mk_frame(pc, mk_box(1000, 1001, 0, 0), pc));
    queue_frame(mk_frame(pc, pc, pc));
    queue_frame(mk_frame(pa, pb, pb));
    repeat (4) queue_frame(random_frame());

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: phase_gate = THRESH_RESET;
        1: phase_gate = THB'($urandom_range(0, 4000));
        2: phase_gate = THB'($urandom_range(0, 16000));
        3: phase_gate = THB'($urandom_range(0, GATE_MAX));
        4: phase_gate = THB'(800);
        default: phase_gate = THB'($urandom_range(0, 2000));
      endcase
      write_gate(phase_gate);
      repeat (85) queue_frame(random_frame());
    end

    wait_idle();
    repeat (250) @(negedge clk);
    if (fail_count == 0 && scores_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
